// ----- hw/rtl/ssca_pkg.sv -----
package ssca_pkg;

    localparam int PAGE_BYTES     = 4096;
    localparam int NUM_PAGES      = 64;
    localparam int MIN_SLOT_BYTES = 8;

    localparam int SLOTS_PER_PAGE = PAGE_BYTES / MIN_SLOT_BYTES;
    localparam int NUM_SLOTS      = NUM_PAGES * SLOTS_PER_PAGE;
    localparam int NUM_CLASSES    = $clog2(PAGE_BYTES / MIN_SLOT_BYTES) + 1;

    localparam int OP_W    = 1;
    localparam int SIZE_W  = 19;
    localparam int ADDR_W  = 18;
    localparam int STAT_W  = 2;
    localparam int PG_W    = $clog2(NUM_PAGES + 1);
    localparam int PIDX_W  = $clog2(NUM_PAGES);
    localparam int SL_W    = $clog2(NUM_SLOTS + 1);
    localparam int SIDX_W  = $clog2(NUM_SLOTS);
    localparam int SPP_W   = $clog2(SLOTS_PER_PAGE);
    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int CNT_W   = 10;
    localparam int MSB_SH  = $clog2(MIN_SLOT_BYTES);
    localparam int PG_SH   = $clog2(PAGE_BYTES);

    localparam int IN_W    = ((OP_W + SIZE_W + ADDR_W + 7) / 8) * 8;
    localparam int OUT_W   = ((ADDR_W + STAT_W + 7) / 8) * 8;

    localparam logic [PG_W-1:0]  PAGE_NONE = PG_W'(NUM_PAGES);
    localparam logic [SL_W-1:0]  SLOT_NONE = SL_W'(NUM_SLOTS);
    localparam logic [CNT_W-1:0] USE_MAX   = {CNT_W{1'b1}};

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_PAGE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_IGNORED   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEC,
        ST_A_CHK,
        ST_A_ATT,
        ST_A_CHAIN,
        ST_A_POP,
        ST_F_CHK,
        ST_F_PUSH,
        ST_R_RD,
        ST_R_WR,
        ST_R_END,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/slab_size_class_allocator_top.sv -----
// Slab allocator, power-of-two size classes over a fixed page store.
// Input channel s_*: one word per request (alloc or free). Output channel
// m_*: one word per request with the address and status.
// One request at a time: s_tready is high only while idle; the result
// word sits in an output register until m_tready takes it.
// Per word: an alloc with a non-empty class list pops its head slot;
// an alloc with an empty list first attaches a free page and chains
// its slots into the list, one slot per cycle; a free pushes the slot
// back on its class list, and when a page falls empty while another
// spare page is held, it unlinks that spare page's slots and returns
// that page to the free page list. Rejects leave the lists unchanged.
// The slot link memories have one write and one registered read port each.
// Reset: all class lists empty, every page unattached, use counts zero;
// per-entry valid bits stand in for the cleared tables, so no clearing
// pass is needed and the block is ready straight after reset.
// A stalled receiver holds the result and keeps s_tready low.
module slab_size_class_allocator_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ssca_pkg::IN_W-1:0]  s_tdata,   // op, request_size, block_address
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ssca_pkg::OUT_W-1:0] m_tdata    // result_address, status
);
    import ssca_pkg::*;

    state_t state_reg, state_next;

    logic                  op_reg, op_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [CLS_W-1:0]      cls_reg, cls_next;
    logic [PIDX_W-1:0]     page_reg, page_next;
    logic [SL_W-1:0]       slot_reg, slot_next;
    logic [SIDX_W-1:0]     s_reg, s_next;
    logic [SL_W-1:0]       prev_reg, prev_next;
    logic [SPP_W-1:0]      left_reg, left_next;
    logic [CNT_W-1:0]      ucnt_reg, ucnt_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [STAT_W-1:0]     res_st_reg, res_st_next;
    logic [PG_W-1:0]       fph_reg, fph_next;
    logic [SL_W-1:0]       head_reg [NUM_CLASSES];
    logic [SL_W-1:0]       head_next [NUM_CLASSES];
    logic [PG_W-1:0]       spare_reg [NUM_CLASSES];
    logic [PG_W-1:0]       spare_next [NUM_CLASSES];

    // slot link memories
    logic [SL_W-1:0]   nxt_mem [NUM_SLOTS];
    logic [SL_W-1:0]   prv_mem [NUM_SLOTS];
    logic              nxt_we, prv_we;
    logic [SIDX_W-1:0] nxt_wa, prv_wa, nxt_ra, prv_ra;
    logic [SL_W-1:0]   nxt_wd, prv_wd, nxt_rd, prv_rd;

    // page tables
    logic [CNT_W-1:0]  cnt_mem [NUM_PAGES];
    logic [PG_W-1:0]   fpl_mem [NUM_PAGES];
    logic [CLS_W-1:0]  cls_mem [NUM_PAGES];
    logic [NUM_PAGES-1:0] cnt_vld_reg, fpl_vld_reg;
    logic              cnt_we, fpl_we, cls_we;
    logic [PIDX_W-1:0] cnt_wa, fpl_wa, cls_wa, cnt_ra, fpl_ra, cls_ra;
    logic [CNT_W-1:0]  cnt_wd, cnt_rd, cnt_val;
    logic [PG_W-1:0]   fpl_wd, fpl_rd, fpl_val;
    logic [CLS_W-1:0]  cls_wd, cls_rd;
    logic              cnt_rv, fpl_rv;
    logic [PIDX_W-1:0] fpl_ra_q;

    // shared walk adder and decode
    logic [SIDX_W-1:0] step;
    logic [SIDX_W-1:0] s_adv;
    logic [SIZE_W-1:0] sz_eff;
    logic              too_large;
    logic [CLS_W-1:0]  c_calc;
    logic [CLS_W-1:0]  c_free;
    logic              misaligned;
    logic [SL_W-1:0]   hd;

    assign step  = SIDX_W'(1) << cls_reg;
    assign s_adv = s_reg + step;
    assign hd    = head_reg[cls_reg];
    assign sz_eff    = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign too_large = sz_eff > SIZE_W'(PAGE_BYTES);

    always_comb
    begin
        c_calc = '0;
        for (int k = 0; k < NUM_CLASSES - 1; k++)
        begin
            if ((SIZE_W'(MIN_SLOT_BYTES) << k) < sz_eff)
                c_calc = CLS_W'(k + 1);
        end
    end

    assign c_free = (cls_rd >= CLS_W'(NUM_CLASSES)) ? CLS_W'(NUM_CLASSES - 1) : cls_rd;
    assign misaligned = (addr_reg & ((ADDR_W'(MIN_SLOT_BYTES) << c_free) - ADDR_W'(1))) != '0;
    assign cnt_val = cnt_rv ? cnt_rd : '0;
    assign fpl_val = fpl_rv ? fpl_rd : PG_W'(fpl_ra_q) + PG_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_DEC;
            ST_DEC:
                if (op_reg == OP_FREE)
                    state_next = ST_F_CHK;
                else if (too_large)
                    state_next = ST_DONE;
                else
                    state_next = ST_A_CHK;
            ST_A_CHK:
                if (hd != SLOT_NONE)
                    state_next = ST_A_POP;
                else if (fph_reg == PAGE_NONE)
                    state_next = ST_DONE;
                else
                    state_next = ST_A_ATT;
            ST_A_ATT:
                state_next = ST_A_CHAIN;
            ST_A_CHAIN:
                if (left_reg == '0)
                    state_next = ST_A_CHK;
            ST_A_POP:
                state_next = ST_DONE;
            ST_F_CHK:
                if (cnt_val == '0 || misaligned)
                    state_next = ST_DONE;
                else
                    state_next = ST_F_PUSH;
            ST_F_PUSH:
                if (ucnt_reg == '0 && spare_reg[cls_reg] != PG_W'(page_reg)
                    && spare_reg[cls_reg] != PAGE_NONE)
                    state_next = ST_R_RD;
                else
                    state_next = ST_DONE;
            ST_R_RD:
                state_next = ST_R_WR;
            ST_R_WR:
                if (left_reg == '0)
                    state_next = ST_R_END;
                else
                    state_next = ST_R_RD;
            ST_R_END:
                state_next = ST_DONE;
            ST_DONE:
                if (m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        cls_next      = cls_reg;
        page_next     = page_reg;
        slot_next     = slot_reg;
        s_next        = s_reg;
        prev_next     = prev_reg;
        left_next     = left_reg;
        ucnt_next     = ucnt_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        fph_next      = fph_reg;
        head_next     = head_reg;
        spare_next    = spare_reg;
        nxt_we = 1'b0; nxt_wa = s_reg; nxt_wd = prev_reg; nxt_ra = s_reg;
        prv_we = 1'b0; prv_wa = s_reg; prv_wd = prev_reg; prv_ra = s_reg;
        cnt_we = 1'b0; cnt_wa = page_reg; cnt_wd = '0; cnt_ra = page_reg;
        fpl_we = 1'b0; fpl_wa = page_reg; fpl_wd = fph_reg; fpl_ra = fph_reg[PIDX_W-1:0];
        cls_we = 1'b0; cls_wa = page_reg; cls_wd = cls_reg;
        cls_ra = addr_reg[PG_SH +: PIDX_W];
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    op_next   = s_tdata[0];
                    size_next = s_tdata[OP_W +: SIZE_W];
                    addr_next = s_tdata[OP_W + SIZE_W +: ADDR_W];
                end
            ST_DEC:
            begin
                res_addr_next = '0;
                res_st_next   = STAT_OK;
                // block_address is 18 bits, so its page is always in the store
                page_next     = addr_reg[PG_SH +: PIDX_W];
                cnt_ra        = addr_reg[PG_SH +: PIDX_W];
                if (op_reg == OP_ALLOC)
                begin
                    cls_next = c_calc;
                    if (too_large)
                        res_st_next = STAT_TOO_LARGE;
                end
            end
            ST_A_CHK:
                if (hd != SLOT_NONE)
                begin
                    slot_next = hd;
                    page_next = hd[SPP_W +: PIDX_W];
                    cnt_ra    = hd[SPP_W +: PIDX_W];
                    nxt_ra    = hd[SIDX_W-1:0];
                end
                else if (fph_reg == PAGE_NONE)
                    res_st_next = STAT_NO_PAGE;
                else
                    page_next = fph_reg[PIDX_W-1:0];
            ST_A_ATT:
            begin
                fph_next  = fpl_val;
                s_next    = {page_reg, {SPP_W{1'b0}}};
                left_next = SPP_W'((SLOTS_PER_PAGE >> cls_reg) - 1);
                prev_next = SLOT_NONE;
            end
            ST_A_CHAIN:
            begin
                prv_we = 1'b1; prv_wa = s_reg; prv_wd = prev_reg;
                nxt_we = 1'b1; nxt_wa = s_reg;
                nxt_wd = (left_reg == '0) ? hd : SL_W'(s_adv);
                prev_next = SL_W'(s_reg);
                s_next    = s_adv;
                left_next = left_reg - SPP_W'(1);
                if (left_reg == '0)
                begin
                    head_next[cls_reg]  = SL_W'({page_reg, {SPP_W{1'b0}}});
                    spare_next[cls_reg] = PG_W'(page_reg);
                    cls_we = 1'b1;
                    cnt_we = 1'b1; cnt_wd = '0;
                end
            end
            ST_A_POP:
            begin
                cnt_we = 1'b1;
                cnt_wd = (cnt_val < USE_MAX) ? cnt_val + CNT_W'(1) : cnt_val;
                if (spare_reg[cls_reg] == PG_W'(page_reg))
                    spare_next[cls_reg] = PAGE_NONE;
                head_next[cls_reg] = nxt_rd;
                if (nxt_rd != SLOT_NONE)
                begin
                    prv_we = 1'b1; prv_wa = nxt_rd[SIDX_W-1:0]; prv_wd = SLOT_NONE;
                end
                res_addr_next = {slot_reg[SIDX_W-1:0], {MSB_SH{1'b0}}};
            end
            ST_F_CHK:
                if (cnt_val == '0 || misaligned)
                    res_st_next = STAT_IGNORED;
                else
                begin
                    cls_next  = c_free;
                    slot_next = SL_W'(addr_reg[ADDR_W-1:MSB_SH]);
                    ucnt_next = cnt_val - CNT_W'(1);
                    prv_we = 1'b1; prv_wa = addr_reg[ADDR_W-1:MSB_SH]; prv_wd = SLOT_NONE;
                    nxt_we = 1'b1; nxt_wa = addr_reg[ADDR_W-1:MSB_SH];
                    nxt_wd = head_reg[c_free];
                end
            ST_F_PUSH:
            begin
                if (hd != SLOT_NONE)
                begin
                    prv_we = 1'b1; prv_wa = hd[SIDX_W-1:0]; prv_wd = slot_reg;
                end
                head_next[cls_reg] = slot_reg;
                cnt_we = 1'b1; cnt_wd = ucnt_reg;
                s_next    = {spare_reg[cls_reg][PIDX_W-1:0], {SPP_W{1'b0}}};
                left_next = SPP_W'((SLOTS_PER_PAGE >> cls_reg) - 1);
                if (ucnt_reg == '0 && (spare_reg[cls_reg] == PG_W'(page_reg)
                    || spare_reg[cls_reg] == PAGE_NONE))
                    spare_next[cls_reg] = PG_W'(page_reg);
            end
            ST_R_RD:
            begin
                nxt_ra = s_reg;
                prv_ra = s_reg;
            end
            ST_R_WR:
            begin
                if (prv_rd != SLOT_NONE)
                begin
                    nxt_we = 1'b1; nxt_wa = prv_rd[SIDX_W-1:0]; nxt_wd = nxt_rd;
                end
                else
                    head_next[cls_reg] = nxt_rd;
                if (nxt_rd != SLOT_NONE)
                begin
                    prv_we = 1'b1; prv_wa = nxt_rd[SIDX_W-1:0]; prv_wd = prv_rd;
                end
                s_next    = s_adv;
                left_next = left_reg - SPP_W'(1);
            end
            ST_R_END:
            begin
                fpl_we = 1'b1;
                fpl_wa = spare_reg[cls_reg][PIDX_W-1:0];
                fpl_wd = fph_reg;
                fph_next = spare_reg[cls_reg];
                spare_next[cls_reg] = PG_W'(page_reg);
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fph_reg     <= '0;
            cnt_vld_reg <= '0;
            fpl_vld_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i]  <= SLOT_NONE;
                spare_reg[i] <= PAGE_NONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            fph_reg   <= fph_next;
            head_reg  <= head_next;
            spare_reg <= spare_next;
            if (cnt_we)
                cnt_vld_reg[cnt_wa] <= 1'b1;
            if (fpl_we)
                fpl_vld_reg[fpl_wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        cls_reg      <= cls_next;
        page_reg     <= page_next;
        slot_reg     <= slot_next;
        s_reg        <= s_next;
        prev_reg     <= prev_next;
        left_reg     <= left_next;
        ucnt_reg     <= ucnt_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[nxt_wa] <= nxt_wd;
        nxt_rd <= nxt_mem[nxt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
            prv_mem[prv_wa] <= prv_wd;
        prv_rd <= prv_mem[prv_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_wa] <= cnt_wd;
        cnt_rd <= cnt_mem[cnt_ra];
        cnt_rv <= cnt_vld_reg[cnt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fpl_we)
            fpl_mem[fpl_wa] <= fpl_wd;
        fpl_rd   <= fpl_mem[fpl_ra];
        fpl_rv   <= fpl_vld_reg[fpl_ra];
        fpl_ra_q <= fpl_ra;
    end

    always_ff @(posedge clk)
    begin
        if (cls_we)
            cls_mem[cls_wa] <= cls_wd;
        cls_rd <= cls_mem[cls_ra];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_DONE);
    assign m_tdata  = {{(OUT_W - ADDR_W - STAT_W){1'b0}}, res_st_reg, res_addr_reg};

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result word is pending");

    a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        fph_reg <= PAGE_NONE)
        else $error("free page head out of range");

    a_reject_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_st_reg != STAT_OK) |-> (res_addr_reg == '0))
        else $error("non-zero address on a rejected request");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");
`endif

endmodule

// ----- dv/slab_alloc_checker.sv -----
module slab_alloc_checker
    import ssca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_W-1:0]   m_tdata,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] status;
    } alloc_result_t;

    alloc_result_t expected_results[$];

    logic [SL_W-1:0]  class_head [NUM_CLASSES];
    logic [PG_W-1:0]  class_spare [NUM_CLASSES];
    logic [PG_W-1:0]  unattached_head;
    logic [PG_W-1:0]  unattached_link [NUM_PAGES];
    logic [CNT_W-1:0] use_count [NUM_PAGES];
    logic [CLS_W-1:0] page_class [NUM_PAGES];
    logic [SL_W-1:0]  slot_next [NUM_SLOTS];
    logic [SL_W-1:0]  slot_prev [NUM_SLOTS];

    initial
    begin
        errors = 0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            class_head[c]  = SLOT_NONE;
            class_spare[c] = PAGE_NONE;
        end
        unattached_head = '0;
        for (int p = 0; p < NUM_PAGES; p++)
        begin
            unattached_link[p] = PG_W'(p + 1);
            use_count[p]       = '0;
            page_class[p]      = '0;
        end
    end

    assign pending = expected_results.size();

    task automatic return_spare(input int c);
        int pg;
        int s;
        int nx;
        int pv;
        pg = class_spare[c];
        if (pg >= NUM_PAGES)
            return;
        class_spare[c] = PAGE_NONE;
        for (int i = 0; i < (SLOTS_PER_PAGE >> c); i++)
        begin
            s  = pg * SLOTS_PER_PAGE + (i << c);
            nx = slot_next[s];
            pv = slot_prev[s];
            if (pv < NUM_SLOTS)
                slot_next[pv] = SL_W'(nx);
            else
                class_head[c] = SL_W'(nx);
            if (nx < NUM_SLOTS)
                slot_prev[nx] = SL_W'(pv);
        end
        unattached_link[pg] = unattached_head;
        unattached_head     = PG_W'(pg);
    endtask

    function automatic bit attach_page(input int c);
        int pg;
        int cnt;
        int base;
        int s;
        int prv;
        pg = unattached_head;
        if (pg >= NUM_PAGES)
            return 0;
        unattached_head = unattached_link[pg];
        cnt  = SLOTS_PER_PAGE >> c;
        if (cnt == 0)
            cnt = 1;
        base = pg * SLOTS_PER_PAGE;
        prv  = NUM_SLOTS;
        for (int i = 0; i < cnt; i++)
        begin
            s = base + (i << c);
            slot_prev[s] = SL_W'(prv);
            slot_next[s] = (i + 1 < cnt) ? SL_W'(s + (1 << c)) : class_head[c];
            prv = s;
        end
        class_head[c]  = SL_W'(base);
        page_class[pg] = CLS_W'(c);
        use_count[pg]  = '0;
        class_spare[c] = PG_W'(pg);
        return 1;
    endfunction

    task automatic predict_request(input logic [IN_W-1:0] w);
        alloc_result_t r;
        logic            op;
        int              size;
        int              addr;
        int              c;
        int              s;
        int              pg;
        int              nx;
        int              hd;
        op   = w[0];
        size = int'(w[OP_W +: SIZE_W]);
        addr = int'(w[OP_W + SIZE_W +: ADDR_W]);
        r    = '0;
        if (op == OP_ALLOC)
        begin
            if (size == 0)
                size = 1;
            if (size > PAGE_BYTES)
                r.status = STAT_TOO_LARGE;
            else
            begin
                c = 0;
                while (c + 1 < NUM_CLASSES && (MIN_SLOT_BYTES << c) < size)
                    c++;
                if (class_head[c] >= SLOT_NONE && !attach_page(c))
                    r.status = STAT_NO_PAGE;
                else
                begin
                    s  = class_head[c];
                    pg = s / SLOTS_PER_PAGE;
                    if (use_count[pg] < USE_MAX)
                        use_count[pg]++;
                    if (class_spare[c] == pg)
                        class_spare[c] = PAGE_NONE;
                    nx = slot_next[s];
                    class_head[c] = SL_W'(nx);
                    if (nx < NUM_SLOTS)
                        slot_prev[nx] = SLOT_NONE;
                    r.addr   = ADDR_W'(s * MIN_SLOT_BYTES);
                    r.status = STAT_OK;
                end
            end
        end
        else
        begin
            pg = addr / PAGE_BYTES;
            if (pg >= NUM_PAGES || use_count[pg] == 0)
                r.status = STAT_IGNORED;
            else
            begin
                c = page_class[pg];
                if (c >= NUM_CLASSES)
                    c = NUM_CLASSES - 1;
                if ((addr & ((MIN_SLOT_BYTES << c) - 1)) != 0)
                    r.status = STAT_IGNORED;
                else
                begin
                    s  = addr / MIN_SLOT_BYTES;
                    hd = class_head[c];
                    slot_prev[s] = SLOT_NONE;
                    slot_next[s] = SL_W'(hd);
                    if (hd < NUM_SLOTS)
                        slot_prev[hd] = SL_W'(s);
                    class_head[c] = SL_W'(s);
                    use_count[pg]--;
                    if (use_count[pg] == 0)
                    begin
                        if (class_spare[c] != pg)
                            return_spare(c);
                        class_spare[c] = PG_W'(pg);
                    end
                    r.status = STAT_OK;
                end
            end
        end
        expected_results.push_back(r);
    endtask

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && s_tvalid && s_tready)
            predict_request(s_tdata);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_tdata[ADDR_W-1:0] !== e.addr)
                begin
                    $display("%0t: address expected %h actual %h", $time, e.addr,
                             m_tdata[ADDR_W-1:0]);
                    errors++;
                end
                if (m_tdata[ADDR_W +: STAT_W] !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             m_tdata[ADDR_W +: STAT_W]);
                    errors++;
                end
            end
        end
    end

endmodule

// ----- dv/slab_size_class_allocator_top_tb.sv -----
module slab_size_class_allocator_top_tb;
    import ssca_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    int               errors;
    int               pending;

    logic                sent_ops[$];
    logic [ADDR_W-1:0]   live_blocks[$];
    bit                  tx_idle;
    bit                  rx_idle;
    int                  results_taken;
    int                  quiet_cycles = 0;

    always #4 clk = ~clk;

    slab_size_class_allocator_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    slab_alloc_checker chk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    task automatic send_word(input logic op, input logic [SIZE_W-1:0] size,
                             input logic [ADDR_W-1:0] addr);
        int gap;
        s_tdata  <= IN_W'({addr, size, op});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent_ops.push_back(op);
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic alloc_word(input int size);
        send_word(OP_ALLOC, SIZE_W'(size), ADDR_W'($urandom_range(0, 262143)));
    endtask

    task automatic free_word(input int addr);
        send_word(OP_FREE, SIZE_W'($urandom_range(0, 262144)), ADDR_W'(addr));
    endtask

    task automatic free_live(input bit keep);
        int idx;
        int a;
        if (live_blocks.size() == 0)
        begin
            free_word($urandom_range(0, 262143));
            return;
        end
        idx = $urandom_range(0, live_blocks.size() - 1);
        a   = live_blocks[idx];
        if (!keep)
            live_blocks.delete(idx);
        free_word(a);
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 64);
            4, 5:       return $urandom_range(65, 512);
            6, 7:       return $urandom_range(513, 4096);
            8:          return $urandom_range(4097, 262144);
            default:    return 1 << $urandom_range(0, 12);
        endcase
    endfunction

    // receiver: random stalls, one long hold-off to back the block up
    initial
    begin
        int gap;
        logic op;
        results_taken = 0;
        rx_idle = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (results_taken % 100 == 0)
                rx_idle = ($urandom_range(0, 3) != 0);
            gap = rx_idle ? $urandom_range(0, 13) : 0;
            if (results_taken == 300)
                gap = 400;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            op = sent_ops.pop_front();
            if (op == OP_ALLOC && m_tdata[ADDR_W +: STAT_W] == STAT_OK)
                live_blocks.push_back(m_tdata[ADDR_W-1:0]);
            results_taken++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int k;
        tx_idle = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        alloc_word(0);
        alloc_word(1);
        free_word(4);
        free_word(8);
        free_word(8);
        free_word(0);
        free_word(200000);
        free_word(262143);
        alloc_word(4097);
        alloc_word(262143);
        alloc_word(262144);
        for (int c = 0; c < NUM_CLASSES; c++)
            alloc_word(MIN_SLOT_BYTES << c);
        alloc_word(9);
        alloc_word(2049);

        for (int epoch = 0; epoch < 14; epoch++)
        begin
            mode    = $urandom_range(0, 2);
            tx_idle = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 100; i++)
            begin
                k = $urandom_range(0, 99);
                case (mode)
                    0:
                        if (k < 50)
                            alloc_word(pick_size());
                        else if (k < 90)
                            free_live(k >= 88);
                        else if (k < 95)
                            free_word($urandom_range(0, 262143));
                        else if (live_blocks.size() > 0)
                            free_word(live_blocks[$urandom_range(0,
                                      live_blocks.size() - 1)] + 4);
                        else
                            free_word($urandom_range(0, 262143));
                    1:
                        if (k < 80)
                            alloc_word($urandom_range(1025, 4096));
                        else if (k < 90)
                            alloc_word(pick_size());
                        else
                            free_live(1'b0);
                    default:
                        if (k < 85)
                            free_live(1'b0);
                        else
                            alloc_word(pick_size());
                endcase
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0 || sent_ops.size() != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
